@@ design/text_console_cursor_engine_top_assert.svh @@
// Assertion macros used by the checker file
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_TOP_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_TOP_ASSERT_SVH

// Clocked assertion, switched off while reset is low
`define TCCE_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define TCCE_ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/tcce_pkg.sv @@
package tcce_pkg;

    // Control codes
    localparam logic [7:0] CODE_BS  = 8'h08;
    localparam logic [7:0] CODE_TAB = 8'h09;
    localparam logic [7:0] CODE_LF  = 8'h0A;
    localparam logic [7:0] CODE_CR  = 8'h0D;

    // Tab stops fall on multiples of this
    localparam logic [8:0] TAB_STOP = 9'd8;

    // Register reset values
    localparam logic [7:0] COLUMNS_RST   = 8'd80;
    localparam logic [7:0] ROWS_RST      = 8'd25;
    localparam logic [7:0] TEXT_ATTR_RST = 8'h0F;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_COLUMNS   = 2'd0,
        CFG_ROWS      = 2'd1,
        CFG_TEXT_ATTR = 2'd2
    } cfg_index_t;

endpackage

@@ design/text_console_cursor_engine_top.sv @@
// Channel   Handshake                  Payload
// s_        s_valid / s_ready          s_char_code
// m_        m_valid / m_ready          m_cell_*, m_scroll_up, m_cursor_*, m_prev_char
// cfg_      cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One word per cycle sustained while m_ready is high; a word passes through the input
// register and then the result register before it shows on the result port, and a stalled
// result holds it back. The cursor update and both row-times-columns products sit between those two registers.
// Reset (aresetn low at a clock edge) empties both stages, homes the cursor and
// restores the register defaults. The configuration port is always ready.
// While the result waits, the input register still takes one more word.
module text_console_cursor_engine_top
    import tcce_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_char_code,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_cell_write,
    output logic [15:0]            m_cell_address,
    output logic [7:0]             m_cell_char,
    output logic [7:0]             m_cell_attr,
    output logic                   m_scroll_up,
    output logic [15:0]            m_cursor_address,
    output logic [7:0]             m_cursor_col,
    output logic [7:0]             m_cursor_row,
    output logic [7:0]             m_prev_char,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data
);

    logic [7:0]  columns_reg;
    logic [7:0]  rows_reg;
    logic [7:0]  text_attr_reg;

    logic [7:0]  col_reg;
    logic [7:0]  row_reg;
    logic [7:0]  last_reg;

    logic        in_valid_reg;
    logic [7:0]  in_char_reg;

    logic        out_valid_reg;
    logic        cell_write_reg;
    logic [15:0] cell_address_reg;
    logic [7:0]  cell_char_reg;
    logic [7:0]  cell_attr_reg;
    logic        scroll_up_reg;
    logic [15:0] cursor_address_reg;

    logic        load_out;
    logic [7:0]  ncols;
    logic [7:0]  nrows;
    logic        wr;
    logic [7:0]  wcol;
    logic [7:0]  wchar;
    logic [8:0]  col_wide;
    logic        adv;
    logic        scroll;
    logic [8:0]  row_inc;
    logic [7:0]  row_next;
    logic [7:0]  col_next;
    logic [15:0] cell_addr;
    logic [15:0] cursor_addr;

    // Handshakes
    assign load_out  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || load_out;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg   <= COLUMNS_RST;
            rows_reg      <= ROWS_RST;
            text_attr_reg <= TEXT_ATTR_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_COLUMNS:   columns_reg   <= cfg_data;
                CFG_ROWS:      rows_reg      <= cfg_data;
                CFG_TEXT_ATTR: text_attr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Zero size acts as one
    assign ncols = (columns_reg == 8'd0) ? 8'd1 : columns_reg;
    assign nrows = (rows_reg == 8'd0) ? 8'd1 : rows_reg;

    // Cursor update for the word in the input register
    always_comb begin
        wr       = 1'b0;
        wcol     = col_reg;
        wchar    = 8'd0;
        col_wide = {1'b0, col_reg};
        adv      = 1'b0;
        case (in_char_reg)
            CODE_BS: begin
                if (col_reg != 8'd0) begin
                    wr       = 1'b1;
                    wcol     = col_reg - 8'd1;
                    col_wide = {1'b0, col_reg} - 9'd1;
                end
            end
            CODE_TAB: col_wide = ({1'b0, col_reg} + TAB_STOP) & ~(TAB_STOP - 9'd1);
            CODE_LF:  adv      = 1'b1;
            CODE_CR:  col_wide = 9'd0;
            default: begin
                wr       = 1'b1;
                wchar    = in_char_reg;
                col_wide = {1'b0, col_reg} + 9'd1;
            end
        endcase

        // wrap past the last column
        if (col_wide >= {1'b0, ncols}) begin
            col_wide = 9'd0;
            adv      = 1'b1;
        end
        col_next = col_wide[7:0];

        // row advance, held on the last row with a scroll request
        row_inc  = {1'b0, row_reg} + 9'd1;
        scroll   = 1'b0;
        row_next = row_reg;
        if (adv) begin
            if (row_inc >= {1'b0, nrows}) begin
                row_next = nrows - 8'd1;
                scroll   = 1'b1;
            end else begin
                row_next = row_inc[7:0];
            end
        end

        cell_addr   = ({8'd0, row_reg} * {8'd0, ncols}) + {8'd0, wcol};
        cursor_addr = ({8'd0, row_next} * {8'd0, ncols}) + {8'd0, col_next};
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_code;
        end
    end

    // Cursor state, updated as a word moves into the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= 8'd0;
            row_reg  <= 8'd0;
            last_reg <= 8'd0;
        end else if (load_out) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            last_reg <= in_char_reg;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            cell_write_reg     <= wr;
            cell_address_reg   <= wr ? cell_addr : 16'd0;
            cell_char_reg      <= wr ? wchar : 8'd0;
            cell_attr_reg      <= wr ? text_attr_reg : 8'd0;
            scroll_up_reg      <= scroll;
            cursor_address_reg <= cursor_addr;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_cell_write     = cell_write_reg;
    assign m_cell_address   = cell_address_reg;
    assign m_cell_char      = cell_char_reg;
    assign m_cell_attr      = cell_attr_reg;
    assign m_scroll_up      = scroll_up_reg;
    assign m_cursor_address = cursor_address_reg;
    assign m_cursor_col     = col_reg;
    assign m_cursor_row     = row_reg;
    assign m_prev_char      = last_reg;

endmodule

@@ design/tcce_checker.sv @@
`include "text_console_cursor_engine_top_assert.svh"

module tcce_checker (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic [7:0]             s_char_code,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic                   m_cell_write,
    input logic [15:0]            m_cell_address,
    input logic [7:0]             m_cell_char,
    input logic [7:0]             m_cell_attr,
    input logic                   m_scroll_up,
    input logic [15:0]            m_cursor_address,
    input logic [7:0]             m_cursor_col,
    input logic [7:0]             m_cursor_row,
    input logic [7:0]             m_prev_char
);

    // whole result word, for the hold check
    logic [73:0] m_word;

    assign m_word = {m_cell_write, m_cell_address, m_cell_char, m_cell_attr, m_scroll_up,
                     m_cursor_address, m_cursor_col, m_cursor_row, m_prev_char};

    // reset empties the result stage
    `TCCE_ASSERT_CLK(a_reset_clears, aclk, !aresetn |=> !m_valid, "result valid after reset")

    // a stalled result word holds
    `TCCE_ASSERT_RST(a_stall_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_word), "stalled result changed")

    // a waiting input word holds
    `TCCE_ASSERT_RST(a_in_hold, aclk, aresetn, s_valid && !s_ready |=> s_valid && $stable(s_char_code), "waiting input changed")

    // no cell write means empty cell fields
    `TCCE_ASSERT_RST(a_idle_cell, aclk, aresetn, m_valid && !m_cell_write |-> m_cell_address == 16'd0 && m_cell_char == 8'd0 && m_cell_attr == 8'd0, "cell fields set without write")

    // a written non-blank character is the last byte seen
    `TCCE_ASSERT_RST(a_prev_char, aclk, aresetn, m_valid && m_cell_write && m_cell_char != 8'd0 |-> m_prev_char == m_cell_char, "prev_char differs from written char")

endmodule

bind text_console_cursor_engine_top tcce_checker u_tcce_checker (.*);
